// ===== rtl/slt_pkg.sv =====
package slt_pkg;

	localparam int SLOT_W = 5;
	localparam int VAL_W  = 32;

	typedef enum logic [1:0] {
		OP_INSERT  = 2'd0,
		OP_DELETE  = 2'd1,
		OP_SEARCH  = 2'd2,
		OP_READOUT = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_INSERT = 2'd1,
		CELL_DELETE = 2'd2,
		CELL_ROTATE = 2'd3
	} cell_op_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_EXEC = 2'd1,
		S_WALK = 2'd2
	} state_t;

	// broadcast to every cell of the row
	typedef struct packed {
		cell_op_t                 op;
		logic signed [VAL_W-1:0]  key;
	} cell_ctl_t;

endpackage

// ===== rtl/slt_cmd_if.sv =====
interface slt_cmd_if;
	logic                               valid;
	logic                               ready;
	logic [1:0]                         opcode;
	logic signed [slt_pkg::VAL_W-1:0]   value;
	logic [slt_pkg::SLOT_W-1:0]         slot;

	modport source(output valid, opcode, value, slot, input ready);
	modport sink(input valid, opcode, value, slot, output ready);
endinterface

// ===== rtl/slt_rsp_if.sv =====
interface slt_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [1:0]                         status;
	logic [slt_pkg::SLOT_W-1:0]         found_slot;
	logic signed [slt_pkg::VAL_W-1:0]   item_value;
	logic                               last;

	modport source(output valid, status, found_slot, item_value, last, input ready);
	modport sink(input valid, status, found_slot, item_value, last, output ready);
endinterface

// ===== rtl/sorted_linked_list_slot_table.sv =====
// channel  dir  modport          payload
// cmd      in   slt_cmd_if.sink  opcode, value, slot
// rsp      out  slt_rsp_if.source status, found_slot, item_value, last
//
// insert and delete are accepted in IDLE and update the cell row in EXEC
// search and readout walk the row in WALK: the row rotates one cell per cycle
// past the head cell, a full turn, so the rotation of the row sets the rate
// a stalled rsp word holds the rotation wherever a word must be emitted
// reset empties every cell and marks every slot free at once, no clearing pass
module sorted_linked_list_slot_table #(
	parameter int SLOTS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	slt_cmd_if.sink          cmd,
	slt_rsp_if.source        rsp
);
	import slt_pkg::*;

	// slot ids run 1..SLOTS, 0 means none
	localparam int ID_W  = $clog2(SLOTS + 1);
	localparam int IDX_W = $clog2(SLOTS);
	localparam int CMP_W = (ID_W > SLOT_W) ? ID_W : SLOT_W;

	state_t                   state_q, state_d;

	// latched command word
	opcode_t                  op_q;
	logic signed [VAL_W-1:0]  key_q;
	logic [SLOT_W-1:0]        slot_q;

	// walk bookkeeping
	logic [IDX_W-1:0]         step_q;
	logic                     found_q;
	logic                     last_step;

	// cell row: cell 0 is the head of the list, valid cells form a prefix
	logic [SLOTS-1:0]         valid_c;
	logic [ID_W-1:0]          id_c [SLOTS];
	logic signed [VAL_W-1:0]  val_c [SLOTS];
	logic [SLOTS-1:0]         le_c;
	logic [SLOTS-1:0]         past_c;
	cell_ctl_t                ctl;
	cell_op_t                 cell_op;

	// free slot tracking
	logic                     full;
	logic [ID_W-1:0]          alloc_id;
	logic [SLOTS-1:0]         free_map;
	logic                     alloc;
	logic                     rel;
	logic [CMP_W-1:0]         slot_ext;
	logic [CMP_W-1:0]         slot_m1;

	// result word register
	logic                     rsp_vld_q;
	status_t                  rsp_status_q;
	logic [SLOT_W-1:0]        rsp_slot_q;
	logic signed [VAL_W-1:0]  rsp_value_q;
	logic                     rsp_last_q;

	// control decode
	logic                     empty;
	logic                     del_hit;
	logic                     search_hit;
	logic                     can_emit;
	logic                     emit;
	logic                     go;
	logic                     walk_start;
	status_t                  e_status;
	logic [CMP_W-1:0]         e_slot;
	logic signed [VAL_W-1:0]  e_value;
	logic                     e_last;

	assign empty      = !valid_c[0];
	assign del_hit    = past_c[SLOTS-1];
	assign search_hit = valid_c[0] && (val_c[0] == key_q);
	assign last_step  = (step_q == IDX_W'(SLOTS - 1));
	assign can_emit   = !rsp_vld_q || rsp.ready;
	assign slot_ext   = CMP_W'(slot_q);
	assign slot_m1    = slot_ext - CMP_W'(1);

	assign ctl.op  = cell_op;
	assign ctl.key = key_q;

	// ---------------------------------------------------------------
	// the cell row
	// ---------------------------------------------------------------
	for (genvar k = 0; k < SLOTS; k++) begin : g_cell
		logic                     l_valid, l_le, l_past;
		logic [ID_W-1:0]          l_id;
		logic signed [VAL_W-1:0]  l_val;
		logic                     r_valid;
		logic [ID_W-1:0]          r_id;
		logic signed [VAL_W-1:0]  r_val;

		if (k == 0) begin : g_head
			// virtual left neighbor sorts before everything
			assign l_valid = 1'b0;
			assign l_id    = '0;
			assign l_val   = '0;
			assign l_le    = 1'b1;
			assign l_past  = 1'b0;
		end else begin : g_body
			assign l_valid = valid_c[k-1];
			assign l_id    = id_c[k-1];
			assign l_val   = val_c[k-1];
			assign l_le    = le_c[k-1];
			assign l_past  = past_c[k-1];
		end

		if (k == SLOTS - 1) begin : g_tail
			// tail wraps to the head while rotating, fills empty on delete
			assign r_valid = (cell_op == CELL_ROTATE) ? valid_c[0] : 1'b0;
			assign r_id    = id_c[0];
			assign r_val   = val_c[0];
		end else begin : g_mid
			assign r_valid = valid_c[k+1];
			assign r_id    = id_c[k+1];
			assign r_val   = val_c[k+1];
		end

		slt_cell #(
			.ID_W  (ID_W),
			.CMP_W (CMP_W)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.new_id      (alloc_id),
			.del_id      (slot_ext),
			.left_valid  (l_valid),
			.left_id     (l_id),
			.left_val    (l_val),
			.left_le     (l_le),
			.left_past   (l_past),
			.right_valid (r_valid),
			.right_id    (r_id),
			.right_val   (r_val),
			.valid       (valid_c[k]),
			.id          (id_c[k]),
			.val         (val_c[k]),
			.le          (le_c[k]),
			.past        (past_c[k])
		);
	end

	slt_free #(
		.SLOTS (SLOTS),
		.ID_W  (ID_W),
		.IDX_W (IDX_W)
	) u_free (
		.clk      (clk),
		.arst_n   (arst_n),
		.alloc    (alloc),
		.rel      (rel),
		.rel_idx  (slot_m1[IDX_W-1:0]),
		.full     (full),
		.alloc_id (alloc_id),
		.free_map (free_map)
	);

	// ---------------------------------------------------------------
	// next state
	// ---------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (go) begin
					state_d = walk_start ? S_WALK : S_IDLE;
				end
			end
			S_WALK: begin
				if (go && last_step) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// ---------------------------------------------------------------
	// outputs of the sequencer
	// ---------------------------------------------------------------
	always_comb begin
		emit       = 1'b0;
		go         = 1'b0;
		walk_start = 1'b0;
		e_status   = ST_OK;
		e_slot     = '0;
		e_value    = '0;
		e_last     = 1'b1;
		cell_op    = CELL_HOLD;
		alloc      = 1'b0;
		rel        = 1'b0;
		unique case (state_q)
			S_IDLE: begin
			end
			S_EXEC: begin
				unique case (op_q)
					OP_INSERT: begin
						emit = 1'b1;
						if (full) begin
							e_status = ST_FULL;
						end else begin
							e_slot = CMP_W'(alloc_id);
						end
					end
					OP_DELETE: begin
						emit = 1'b1;
						if (empty) begin
							e_status = ST_EMPTY;
						end else if (!del_hit) begin
							e_status = ST_NOT_FOUND;
						end
					end
					OP_SEARCH, OP_READOUT: begin
						if (empty) begin
							emit     = 1'b1;
							e_status = ST_EMPTY;
						end else begin
							walk_start = 1'b1;
						end
					end
					default: begin
					end
				endcase
				go = !emit || can_emit;
				// the row and the free map change only with the result word
				if (go && op_q == OP_INSERT && !full) begin
					cell_op = CELL_INSERT;
					alloc   = 1'b1;
				end
				if (go && op_q == OP_DELETE && !empty && del_hit) begin
					cell_op = CELL_DELETE;
					rel     = 1'b1;
				end
			end
			S_WALK: begin
				if (op_q == OP_READOUT) begin
					// every list entry passes the head once per turn
					emit    = valid_c[0];
					e_slot  = CMP_W'(id_c[0]);
					e_value = val_c[0];
					e_last  = last_step || !valid_c[1];
				end else begin
					// first match in list order, or a miss at the end of the turn
					emit     = !found_q && (search_hit || last_step);
					e_status = search_hit ? ST_OK : ST_NOT_FOUND;
					e_slot   = search_hit ? CMP_W'(id_c[0]) : '0;
				end
				go = !emit || can_emit;
				if (go) begin
					cell_op = CELL_ROTATE;
				end
			end
			default: begin
			end
		endcase
	end

	assign cmd.ready = (state_q == S_IDLE);

	// ---------------------------------------------------------------
	// registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_EXEC) begin
				step_q  <= '0;
				found_q <= 1'b0;
			end else if (state_q == S_WALK && go) begin
				step_q  <= step_q + IDX_W'(1);
				found_q <= found_q || search_hit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_q   <= opcode_t'(cmd.opcode);
			key_q  <= cmd.value;
			slot_q <= cmd.slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (emit && go) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && go) begin
			rsp_status_q <= e_status;
			rsp_slot_q   <= e_slot[SLOT_W-1:0];
			rsp_value_q  <= e_value;
			rsp_last_q   <= e_last;
		end
	end

	assign rsp.valid      = rsp_vld_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.found_slot = rsp_slot_q;
	assign rsp.item_value = rsp_value_q;
	assign rsp.last       = rsp_last_q;

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------

	// between commands the list sits packed at the head of the row
	a_row_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ((valid_c & (valid_c + SLOTS'(1))) == '0))
		else $error("cell row has a gap between commands");

	// every slot is either in the list or free, never both
	a_slot_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (($countones(valid_c) + $countones(free_map)) == SLOTS))
		else $error("list length and free map disagree");

	// the free map moves only when a command executes
	a_free_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_EXEC) |=> $stable(free_map))
		else $error("free map changed outside execution");

endmodule

// ===== rtl/slt_cell.sv =====
module slt_cell #(
	parameter int ID_W  = 5,
	parameter int CMP_W = 5
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  slt_pkg::cell_ctl_t                ctl,
	input  logic [ID_W-1:0]                   new_id,
	input  logic [CMP_W-1:0]                  del_id,
	input  logic                              left_valid,
	input  logic [ID_W-1:0]                   left_id,
	input  logic signed [slt_pkg::VAL_W-1:0]  left_val,
	input  logic                              left_le,
	input  logic                              left_past,
	input  logic                              right_valid,
	input  logic [ID_W-1:0]                   right_id,
	input  logic signed [slt_pkg::VAL_W-1:0]  right_val,
	output logic                              valid,
	output logic [ID_W-1:0]                   id,
	output logic signed [slt_pkg::VAL_W-1:0]  val,
	output logic                              le,
	output logic                              past
);
	import slt_pkg::*;

	logic                     valid_q;
	logic [ID_W-1:0]          id_q;
	logic signed [VAL_W-1:0]  val_q;
	logic                     valid_d;
	logic [ID_W-1:0]          id_d;
	logic signed [VAL_W-1:0]  val_d;

	// le: this entry sorts at or before the key, so an insert lands behind it
	assign le    = valid_q && (val_q <= ctl.key);
	assign past  = left_past || (valid_q && (CMP_W'(id_q) == del_id));
	assign valid = valid_q;
	assign id    = id_q;
	assign val   = val_q;

	always_comb begin
		valid_d = valid_q;
		id_d    = id_q;
		val_d   = val_q;
		unique case (ctl.op)
			CELL_HOLD: begin
			end
			CELL_INSERT: begin
				if (!le) begin
					if (left_le) begin
						valid_d = 1'b1;
						id_d    = new_id;
						val_d   = ctl.key;
					end else begin
						valid_d = left_valid;
						id_d    = left_id;
						val_d   = left_val;
					end
				end
			end
			CELL_DELETE: begin
				if (past) begin
					valid_d = right_valid;
					id_d    = right_id;
					val_d   = right_val;
				end
			end
			CELL_ROTATE: begin
				valid_d = right_valid;
				id_d    = right_id;
				val_d   = right_val;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		id_q  <= id_d;
		val_q <= val_d;
	end

endmodule

// ===== rtl/slt_free.sv =====
module slt_free #(
	parameter int SLOTS = 16,
	parameter int ID_W  = 5,
	parameter int IDX_W = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              alloc,
	input  logic              rel,
	input  logic [IDX_W-1:0]  rel_idx,
	output logic              full,
	output logic [ID_W-1:0]   alloc_id,
	output logic [SLOTS-1:0]  free_map
);
	import slt_pkg::*;

	logic [SLOTS-1:0]  free_q;
	logic [IDX_W-1:0]  alloc_idx;

	// lowest free slot wins
	always_comb begin
		alloc_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (free_q[i]) begin
				alloc_idx = IDX_W'(i);
			end
		end
	end

	assign alloc_id = ID_W'(alloc_idx) + ID_W'(1);
	assign full     = ~|free_q;
	assign free_map = free_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '1;
		end else begin
			if (alloc) begin
				free_q[alloc_idx] <= 1'b0;
			end
			if (rel) begin
				free_q[rel_idx] <= 1'b1;
			end
		end
	end

endmodule
